// ----- hdl/h3d_pkg.sv -----
package h3d_pkg;

  // Default width of the decoded frame length.
  localparam int unsigned LENGTH_WIDTH_DEF = 62;

  // Output queue depth (power of two); one input byte pushes up to three results.
  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_MAX_PUSH = 3;

  // Fixed field widths of a result item.
  localparam int unsigned KIND_W = 2;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_DROP    = 2'd2,
    KIND_FINISH  = 2'd3
  } kind_e;

  // Frame parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_TYPE      = 4'b0001,
    PH_LEN_FIRST = 4'b0010,
    PH_LEN_REST  = 4'b0100,
    PH_PAYLOAD   = 4'b1000
  } phase_e;

  // Number of varint bytes that follow the first one, from its two top bits.
  function automatic logic [2:0] varint_extra(input logic [1:0] size_code);
    logic [2:0] n;
    case (size_code)
      2'd0:    n = 3'd0;
      2'd1:    n = 3'd1;
      2'd2:    n = 3'd3;
      default: n = 3'd7;
    endcase
    return n;
  endfunction

endpackage

// ----- hdl/h3d_parse.sv -----
module h3d_parse import h3d_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF,
  localparam int unsigned IW = LENGTH_WIDTH + 2 * BYTE_W + KIND_W + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   go_i,
  input  logic [BYTE_W-1:0]      data_i,
  input  logic                   last_i,
  // Result slots in order: payload, done or drop, finish.
  // Each slot from bit 0: kind, type, payload_byte, frame_length, any_frame, run_last.
  output logic [2:0]             item_vld_o,
  output logic [2:0][IW-1:0]     item_o
);

  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = {LENGTH_WIDTH{1'b1}};
  localparam logic [LENGTH_WIDTH-1:0] LEN_ZERO = '0;

  phase_e                    phase_q, phase_d;
  logic [BYTE_W-1:0]         type_q, type_d;
  logic [LENGTH_WIDTH-1:0]   acc_q, acc_d;
  logic [2:0]                left_q, left_d;
  logic [LENGTH_WIDTH-1:0]   pay_q, pay_d;
  logic                      found_q, found_d;

  logic [LENGTH_WIDTH+BYTE_W-1:0] wide;
  logic [LENGTH_WIDTH-1:0]        pay_dec;
  logic                           cmp_en;
  logic [LENGTH_WIDTH-1:0]        cmp_val;
  logic                           p_vld, m_vld, f_vld;
  kind_e                          m_kind;
  logic [LENGTH_WIDTH-1:0]        m_len;
  logic [BYTE_W-1:0]              m_type;
  logic                           m_any, f_any;

  assign wide    = {acc_q, data_i};
  assign pay_dec = pay_q - LENGTH_WIDTH'(1);

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    acc_d   = acc_q;
    left_d  = left_q;
    pay_d   = pay_q;
    found_d = found_q;
    cmp_en  = 1'b0;
    cmp_val = acc_q;
    p_vld   = 1'b0;
    m_vld   = 1'b0;
    m_kind  = KIND_DONE;
    m_len   = LEN_ZERO;
    f_vld   = 1'b0;

    case (phase_q)
      PH_TYPE: begin
        type_d  = data_i;
        phase_d = PH_LEN_FIRST;
      end
      PH_LEN_FIRST: begin
        acc_d   = LENGTH_WIDTH'(data_i[5:0]);
        cmp_val = acc_d;
        left_d  = varint_extra(data_i[7:6]);
        if (data_i[7:6] == 2'd0) begin
          cmp_en = 1'b1;
        end else begin
          phase_d = PH_LEN_REST;
        end
      end
      PH_LEN_REST: begin
        // Any bit shifted out past the length width saturates the value.
        acc_d   = (|wide[LENGTH_WIDTH+BYTE_W-1:LENGTH_WIDTH]) ? LEN_MAX
                                                             : wide[LENGTH_WIDTH-1:0];
        cmp_val = acc_d;
        left_d  = left_q - 3'd1;
        cmp_en  = (left_q == 3'd1);
      end
      PH_PAYLOAD: begin
        p_vld = 1'b1;
        pay_d = pay_dec;
        if (pay_dec == LEN_ZERO) begin
          found_d = 1'b1;
          m_vld   = 1'b1;
          m_kind  = KIND_DONE;
          m_len   = acc_q;
          phase_d = PH_TYPE;
        end
      end
      default: begin
        phase_d = PH_TYPE;
      end
    endcase

    // The length field just finished: an empty frame completes at once.
    if (cmp_en) begin
      if (cmp_val == LEN_ZERO) begin
        found_d = 1'b1;
        m_vld   = 1'b1;
        m_kind  = KIND_DONE;
        m_len   = LEN_ZERO;
        phase_d = PH_TYPE;
      end else begin
        pay_d   = cmp_val;
        phase_d = PH_PAYLOAD;
      end
    end

    m_type = type_d;
    m_any  = found_d;
    f_any  = found_d;

    if (last_i) begin
      f_vld = 1'b1;
      if (phase_d != PH_TYPE) begin
        m_vld  = 1'b1;
        m_kind = KIND_DROP;
        m_len  = (phase_d == PH_PAYLOAD) ? acc_d : LEN_ZERO;
      end
      phase_d = PH_TYPE;
      type_d  = '0;
      acc_d   = '0;
      left_d  = '0;
      pay_d   = '0;
      found_d = 1'b0;
    end
  end

  assign item_vld_o = {f_vld, m_vld, p_vld};

  assign item_o[0] = {!m_vld && !f_vld, found_q, acc_q, data_i, type_q, KIND_PAYLOAD};
  assign item_o[1] = {!f_vld, m_any, m_len, {BYTE_W{1'b0}}, m_type, m_kind};
  assign item_o[2] = {1'b1, f_any, LEN_ZERO, {BYTE_W{1'b0}}, {BYTE_W{1'b0}}, KIND_FINISH};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      type_q  <= '0;
      acc_q   <= '0;
      left_q  <= '0;
      pay_q   <= '0;
      found_q <= 1'b0;
    end else if (go_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      pay_q   <= pay_d;
      found_q <= found_d;
    end
  end

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && last_i |=> phase_q == PH_TYPE && !found_q)
    else $error("parser state not cleared after buffer end");

  a_type_then_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && !last_i && phase_q == PH_TYPE |=> phase_q == PH_LEN_FIRST)
    else $error("type byte did not advance to length field");

  a_finish_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |-> item_vld_o[2] == last_i)
    else $error("finish result does not match buffer end");

endmodule

// ----- hdl/h3d_outq.sv -----
module h3d_outq import h3d_pkg::*; #(
  parameter int unsigned DW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [2:0]           push_vld_i,
  input  logic [2:0][DW-1:0]   push_data_i,
  output logic                 room_o,
  output logic                 out_vld_o,
  input  logic                 out_rdy_i,
  output logic [DW-1:0]        out_data_o
);

  localparam int unsigned AW = $clog2(OQ_DEPTH);
  localparam int unsigned CW = $clog2(OQ_DEPTH + 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(OQ_DEPTH - OQ_MAX_PUSH);
  localparam logic [CW-1:0] DEPTH_C = CW'(OQ_DEPTH);

  logic [DW-1:0]      mem_q [OQ_DEPTH];
  logic [AW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [2:0][AW-1:0] waddr;
  logic [1:0]         push_n;
  logic               pop;

  // Each valid slot lands behind the valid slots before it.
  assign waddr[0] = wr_q;
  assign waddr[1] = wr_q + AW'(push_vld_i[0]);
  assign waddr[2] = wr_q + AW'(push_vld_i[0]) + AW'(push_vld_i[1]);
  assign push_n   = 2'(push_vld_i[0]) + 2'(push_vld_i[1]) + 2'(push_vld_i[2]);

  assign out_vld_o  = (cnt_q != '0);
  assign out_data_o = mem_q[rd_q];
  assign pop        = out_vld_o && out_rdy_i;
  assign room_o     = (cnt_q <= ROOM_LIMIT);

  assign wr_d  = wr_q + AW'(push_n);
  assign rd_d  = rd_q + AW'(pop);
  assign cnt_d = cnt_q + CW'(push_n) - CW'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (push_vld_i[k]) begin
        mem_q[waddr[k]] <= push_data_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("output queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n != 2'd0 |-> room_o)
    else $error("push without room");

  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop |=> rd_q == $past(rd_q))
    else $error("read pointer moved without a pop");

endmodule

// ----- hdl/http3_frame_deframer.sv -----
// Path: a byte is registered at the input, parsed combinationally from that register, and
// its result beats are written into the result queue, which offers them on the output.
// Throughput: one input byte per cycle while the result queue has room; a byte that
// yields two or three results holds the output for that many beats, buffered by an
// eight-entry result queue that accepts a byte only with room for three beats.
// Reset: asynchronous, active low; parser returns to expecting a type byte, queue empties.
module http3_frame_deframer import h3d_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF,
  localparam int unsigned TDATA_W = ((2 * BYTE_W + LENGTH_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // data_byte
  input  logic               s_axis_tlast_i,   // buffer_end
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // type, payload_byte, frame_length, any_frame, zero fill
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]         m_axis_tuser_o,   // kind
  output logic               m_axis_tlast_o    // run_last
);

  localparam int unsigned IW = LENGTH_WIDTH + 2 * BYTE_W + KIND_W + 2;
  localparam int unsigned PAD_W = TDATA_W - (2 * BYTE_W + LENGTH_WIDTH + 1);

  logic              in_vld_q;
  logic [7:0]        in_data_q;
  logic              in_last_q;
  logic              room, go;
  logic [2:0]        item_vld;
  logic [2:0][IW-1:0] item;
  logic [IW-1:0]     out_item;

  assign go              = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  h3d_parse #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .data_i     (in_data_q),
    .last_i     (in_last_q),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  h3d_outq #(
    .DW(IW)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_vld_i  (item_vld & {3{go}}),
    .push_data_i (item),
    .room_o      (room),
    .out_vld_o   (m_axis_tvalid_o),
    .out_rdy_i   (m_axis_tready_i),
    .out_data_o  (out_item)
  );

  // Queue entry from bit 0: kind, type, payload_byte, frame_length, any, run_last.
  assign m_axis_tuser_o = out_item[KIND_W-1:0];
  assign m_axis_tlast_o = out_item[IW-1];
  assign m_axis_tdata_o = {{PAD_W{1'b0}}, out_item[IW-2:KIND_W]};

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import h3d_pkg::*;

  localparam int unsigned LW = LENGTH_WIDTH_DEF;
  localparam int unsigned TDATA_W = ((2 * BYTE_W + LW + 1 + 7) / 8) * 8;
  localparam int unsigned RANDOM_BYTES = 445;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    kind_e          kind;
    logic [7:0]     ftype;
    logic [7:0]     payload_byte;
    logic [LW-1:0]  frame_length;
    logic           any_frame;
    logic           run_last;
  } beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } in_byte_t;

  // Holds the parser state of the block and the result beats still owed by it.
  class deframe_scoreboard;
    phase_e      parse_phase;
    logic [7:0]  cur_type;
    logic [63:0] len_acc;
    logic [2:0]  len_left;
    logic [63:0] pay_left;
    logic        got_frame;
    logic [63:0] len_max;
    beat_t       held;
    bit          have_held;
    beat_t       expected_beats[$];
    int          fail_count;

    function new();
      len_max = (64'd1 << LW) - 64'd1;
      have_held = 1'b0;
      fail_count = 0;
      clear_state();
    endfunction

    function void clear_state();
      parse_phase = PH_TYPE;
      cur_type = '0;
      len_acc = '0;
      len_left = '0;
      pay_left = '0;
      got_frame = 1'b0;
    endfunction

    // The last beat of a byte is held back so that its run_last can be set.
    function void push_beat(kind_e k, logic [7:0] t, logic [7:0] p, logic [63:0] len);
      if (have_held) expected_beats.insert(expected_beats.size(), held);
      held.kind = k;
      held.ftype = t;
      held.payload_byte = p;
      held.frame_length = len[LW-1:0];
      held.any_frame = got_frame;
      held.run_last = 1'b0;
      have_held = 1'b1;
    endfunction

    function void length_done();
      if (len_acc == 0) begin
        got_frame = 1'b1;
        push_beat(KIND_DONE, cur_type, 8'h00, 64'd0);
        parse_phase = PH_TYPE;
      end else begin
        pay_left = len_acc;
        parse_phase = PH_PAYLOAD;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eob);
      case (parse_phase)
        PH_TYPE: begin
          cur_type = b;
          parse_phase = PH_LEN_FIRST;
        end
        PH_LEN_FIRST: begin
          len_acc = {58'd0, b[5:0]};
          if (len_acc > len_max) len_acc = len_max;
          len_left = 3'((4'd1 << b[7:6]) - 4'd1);
          if (len_left == 0) begin
            length_done();
          end else begin
            parse_phase = PH_LEN_REST;
          end
        end
        PH_LEN_REST: begin
          if (len_acc > (len_max >> 8)) begin
            len_acc = len_max;
          end else begin
            len_acc = (len_acc << 8) | {56'd0, b};
            if (len_acc > len_max) len_acc = len_max;
          end
          len_left = len_left - 3'd1;
          if (len_left == 0) length_done();
        end
        default: begin
          push_beat(KIND_PAYLOAD, cur_type, b, len_acc);
          pay_left = (pay_left - 64'd1) & len_max;
          if (pay_left == 0) begin
            got_frame = 1'b1;
            push_beat(KIND_DONE, cur_type, 8'h00, len_acc);
            parse_phase = PH_TYPE;
          end
        end
      endcase
      if (eob) begin
        if (parse_phase != PH_TYPE) begin
          push_beat(KIND_DROP, cur_type, 8'h00,
                    (parse_phase == PH_PAYLOAD) ? len_acc : 64'd0);
        end
        push_beat(KIND_FINISH, 8'h00, 8'h00, 64'd0);
        clear_state();
      end
      if (have_held) begin
        held.run_last = 1'b1;
        expected_beats.insert(expected_beats.size(), held);
        have_held = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
        fail_count++;
        if (fail_count <= 40) begin
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
        end
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (expected_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= 40) begin
          $display("%0t: unexpected result beat, expected none, actual kind %0d type %0h",
                   $time, got.kind, got.ftype);
        end
        return;
      end
      want = expected_beats.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("type", want.ftype, got.ftype);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("any_frame", want.any_frame, got.any_frame);
      compare_field("run_last", want.run_last, got.run_last);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_tvalid = 1'b0;
  logic [7:0]         s_tdata = 8'h00;
  logic               s_tlast = 1'b0;
  logic               m_tready = 1'b0;
  wire                s_tready;
  wire                m_tvalid;
  wire [TDATA_W-1:0]  m_tdata;
  wire [1:0]          m_tuser;
  wire                m_tlast;

  deframe_scoreboard sb = new();
  in_byte_t          byte_plan[$];
  logic [7:0]        buf_bytes[$];
  int                cycle_count = 0;

  http3_frame_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Appends one frame: type, varint of 2^size_code bytes, then n_pay payload bytes.
  function automatic void put_frame(logic [7:0] t, logic [63:0] len, int size_code,
                                    int n_pay);
    int         n_len;
    logic [7:0] b;
    n_len = 1 << size_code;
    buf_bytes.insert(buf_bytes.size(), t);
    for (int i = n_len - 1; i >= 0; i--) begin
      b = len[8*i +: 8];
      if (i == n_len - 1) b[7:6] = size_code[1:0];
      buf_bytes.insert(buf_bytes.size(), b);
    end
    for (int i = 0; i < n_pay; i++) buf_bytes.insert(buf_bytes.size(), 8'($urandom));
  endfunction

  function automatic void close_buffer();
    in_byte_t ib;
    foreach (buf_bytes[i]) begin
      ib.data = buf_bytes[i];
      ib.eob = (i == buf_bytes.size() - 1);
      byte_plan.insert(byte_plan.size(), ib);
    end
    buf_bytes.delete();
  endfunction

  function automatic void add_bytes(logic [7:0] a[]);
    foreach (a[i]) buf_bytes.insert(buf_bytes.size(), a[i]);
    close_buffer();
  endfunction

  function automatic void directed_buffers();
    // Full frame whose last payload byte also ends the buffer: three beats at once.
    add_bytes('{8'h00, 8'h02, 8'h00, 8'hFF});
    // Zero-length frames, the second with a four-byte length ending the buffer.
    add_bytes('{8'hFF, 8'h00, 8'h07, 8'h80, 8'h00, 8'h00, 8'h00});
    // Buffer ends right after a type byte.
    add_bytes('{8'h21});
    // Buffer ends inside an eight-byte length field.
    add_bytes('{8'h33, 8'hC0, 8'h12});
    // Largest length, then the payload is cut off.
    add_bytes('{8'h44, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A});
  endfunction

  function automatic void random_buffer();
    int          n_frames;
    int          size_code;
    int          n_cut;
    logic [63:0] len;
    logic [63:0] mask;
    if ($urandom_range(0, 9) == 0) begin
      // Noise: random bytes with no regard for framing.
      n_frames = $urandom_range(1, 6);
      for (int i = 0; i < n_frames; i++) buf_bytes.insert(buf_bytes.size(), 8'($urandom));
      close_buffer();
      return;
    end
    n_frames = $urandom_range(1, 4);
    for (int f = 0; f < n_frames; f++) begin
      size_code = $urandom_range(0, 3);
      if (f == n_frames - 1 && $urandom_range(0, 4) == 0) begin
        mask = (64'd1 << (8 * (1 << size_code) - 2)) - 64'd1;
        len = {$urandom, $urandom} & mask;
        put_frame(8'($urandom), len, size_code, $urandom_range(0, 4));
      end else begin
        len = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom_range(1, 10));
        put_frame(8'($urandom), len, size_code, int'(len));
      end
    end
    if ($urandom_range(0, 3) == 0 && buf_bytes.size() > 1) begin
      n_cut = $urandom_range(1, buf_bytes.size() - 1);
      repeat (n_cut) void'(buf_bytes.pop_back());
    end
    close_buffer();
  endfunction

  task automatic send_byte(logic [7:0] d, logic eob, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= eob;
    do @(posedge clk_i); while (s_tready !== 1'b1);
    sb.note_byte(d, eob);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    int dir_end;
    int mid_mark;
    int gap;
    directed_buffers();
    dir_end = byte_plan.size();
    while (byte_plan.size() < dir_end + RANDOM_BYTES / 2) random_buffer();
    mid_mark = byte_plan.size();
    while (byte_plan.size() < dir_end + RANDOM_BYTES) random_buffer();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < byte_plan.size(); i++) begin
      if (i == dir_end || i == mid_mark) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
      // A stretch of back-to-back beats early in the random part.
      if (i >= dir_end + 40 && i < dir_end + 100) gap = 0;
      else gap = $urandom_range(0, 8);
      send_byte(byte_plan[i].data, byte_plan[i].eob, gap);
    end
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int    stall;
    int    accepted;
    beat_t got;
    accepted = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // One long hold-off lets the result queue fill and stall the input side.
      if (accepted == 40) stall = 300;
      else if (accepted >= 200 && accepted < 260) stall = 0;
      else stall = $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (m_tvalid !== 1'b1);
      got.kind = kind_e'(m_tuser);
      got.ftype = m_tdata[7:0];
      got.payload_byte = m_tdata[15:8];
      got.frame_length = m_tdata[16 +: LW];
      got.any_frame = m_tdata[16 + LW];
      got.run_last = m_tlast;
      sb.check_beat(got);
      accepted++;
    end
  end

endmodule
